[sv/cdc_pkg.sv]
// Shared types and codes for the coherence directory controller.
// No dependencies; imported by the controller, datapath and top level.
package cdc_pkg;

  // Default sizes, handed down through the top-level parameters
  localparam int unsigned NumCoresDef  = 16;
  localparam int unsigned DirLinesDef  = 256;
  localparam int unsigned WaitDepthDef = 4;

  // Input operation codes
  localparam logic [1:0] OP_REQ   = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_EVICT = 2'd2;

  // Result message kinds
  localparam logic [1:0] MSG_DATA = 2'd0;
  localparam logic [1:0] MSG_INV  = 2'd1;
  localparam logic [1:0] MSG_NONE = 2'd2;
  localparam logic [1:0] MSG_OVF  = 2'd3;

  // Line state and cache state encodings (same codes)
  localparam logic [1:0] LS_UNC = 2'd0;
  localparam logic [1:0] LS_SHR = 2'd1;
  localparam logic [1:0] LS_EXC = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MAX_SHARERS = 1'b0;
  localparam logic CFG_LIMITLESS   = 1'b1;

  // Register reset values
  localparam logic [4:0] MaxSharersRst = 5'd16;
  localparam logic [4:0] LimitlessRst  = 5'd0;

  // Controller to datapath: one step per cycle
  typedef struct packed {
    logic clr;       // write a zero record during the clearing pass
    logic accept;    // latch the item, read its line record
    logic load_rec;  // take the record read data
    logic dec;       // decode the item against the record
    logic load_ent;  // take the queue head entry
    logic ack;       // apply an acknowledgement
    logic run;       // process the head request
    logic fan;       // send one invalidation of a fan-out
    logic wb;        // write the record back
  } cmd_t;

  // Datapath to controller: branch decisions
  typedef struct packed {
    logic clr_done;
    logic dec_run;
    logic dec_ack;
    logic ack_run;
    logic run_fan;
    logic run_more;
    logic fan_done;
  } sts_t;

endpackage

[sv/coherence_directory_controller.sv]
// Top level of the coherence directory controller.
// Depends on cdc_pkg, cdc_ctrl and cdc_dpath.

// An item is taken when start is high and busy is low. Eviction notices,
// stray acks, queued requests and overflows pass the REC, DEC and WB states;
// an ack that stops at the head request adds FRD_ACK and ACK, a request that
// reaches it RUN, an ack that resumes it all three, plus one invalidation per
// cycle in a write fan-out and FRD_RUN and RUN per queued request completing
// behind it. The sequencer handles one item at a time and each line record
// goes through one read and one write-back. Results come at most one per
// cycle on result_valid_o and cannot be held off; last_o marks the final
// result of an item. After reset the directory is cleared one line a cycle,
// all DirLines lines, with busy high; configuration writes are taken at any
// time (cfg_ready_o is always high) but belong between items.
module coherence_directory_controller #(
  parameter int unsigned NumCores  = cdc_pkg::NumCoresDef,
  parameter int unsigned DirLines  = cdc_pkg::DirLinesDef,
  parameter int unsigned WaitDepth = cdc_pkg::WaitDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [7:0] line_index_i,
  input  logic [3:0] core_id_i,
  input  logic       is_write_i,
  input  logic       removed_already_i,
  input  logic       carries_writeback_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [4:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [1:0] msg_kind_o,
  output logic [3:0] dest_core_o,
  output logic [1:0] new_cache_state_o,
  output logic [7:0] out_line_o,
  output logic       memory_read_o,
  output logic       memory_write_o,
  output logic       trap_flag_o,
  output logic       last_o
);
  import cdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  cdc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cdc_dpath #(
    .NumCores  (NumCores),
    .DirLines  (DirLines),
    .WaitDepth (WaitDepth)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .operation_i         (operation_i),
    .line_index_i        (line_index_i),
    .core_id_i           (core_id_i),
    .is_write_i          (is_write_i),
    .removed_already_i   (removed_already_i),
    .carries_writeback_i (carries_writeback_i),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .msg_kind_o          (msg_kind_o),
    .dest_core_o         (dest_core_o),
    .new_cache_state_o   (new_cache_state_o),
    .out_line_o          (out_line_o),
    .memory_read_o       (memory_read_o),
    .memory_write_o      (memory_write_o),
    .trap_flag_o         (trap_flag_o),
    .last_o              (last_o)
  );

endmodule

[sv/cdc_ctrl.sv]
// Sequencer of the coherence directory controller.
// Depends on cdc_pkg for the command and status structs.
module cdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cdc_pkg::sts_t sts_i,
  output cdc_pkg::cmd_t cmd_o
);
  import cdc_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_REC     = 4'd2;
  localparam logic [3:0] S_DEC     = 4'd3;
  localparam logic [3:0] S_FRD_ACK = 4'd4;
  localparam logic [3:0] S_ACK     = 4'd5;
  localparam logic [3:0] S_RUN     = 4'd6;
  localparam logic [3:0] S_FRD_RUN = 4'd7;
  localparam logic [3:0] S_FAN     = 4'd8;
  localparam logic [3:0] S_WB      = 4'd9;

  logic [3:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Next state and step commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_REC;
        end
      end
      S_REC: begin
        cmd_o.load_rec = 1'b1;
        state_d        = S_DEC;
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        priority if (sts_i.dec_run) state_d = S_RUN;
        else if (sts_i.dec_ack)     state_d = S_FRD_ACK;
        else                        state_d = S_WB;
      end
      S_FRD_ACK: begin
        cmd_o.load_ent = 1'b1;
        state_d        = S_ACK;
      end
      S_ACK: begin
        cmd_o.ack = 1'b1;
        state_d   = sts_i.ack_run ? S_RUN : S_WB;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        priority if (sts_i.run_fan) state_d = S_FAN;
        else if (sts_i.run_more)    state_d = S_FRD_RUN;
        else                        state_d = S_WB;
      end
      S_FRD_RUN: begin
        cmd_o.load_ent = 1'b1;
        state_d        = S_RUN;
      end
      S_FAN: begin
        cmd_o.fan = 1'b1;
        if (sts_i.fan_done) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/cdc_dpath.sv]
// Datapath of the coherence directory controller: line records, wait queues,
// configuration registers and result registers. Depends on cdc_pkg.
module cdc_dpath #(
  parameter int unsigned NumCores  = cdc_pkg::NumCoresDef,
  parameter int unsigned DirLines  = cdc_pkg::DirLinesDef,
  parameter int unsigned WaitDepth = cdc_pkg::WaitDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cdc_pkg::cmd_t cmd_i,
  output cdc_pkg::sts_t sts_o,
  input  logic [1:0]    operation_i,
  input  logic [7:0]    line_index_i,
  input  logic [3:0]    core_id_i,
  input  logic          is_write_i,
  input  logic          removed_already_i,
  input  logic          carries_writeback_i,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [4:0]    cfg_data_i,
  output logic          result_valid_o,
  output logic [1:0]    msg_kind_o,
  output logic [3:0]    dest_core_o,
  output logic [1:0]    new_cache_state_o,
  output logic [7:0]    out_line_o,
  output logic          memory_read_o,
  output logic          memory_write_o,
  output logic          trap_flag_o,
  output logic          last_o
);
  import cdc_pkg::*;

  localparam int unsigned CW  = (NumCores > 1) ? $clog2(NumCores) : 1;
  localparam int unsigned LW  = $clog2(DirLines);
  localparam int unsigned PW  = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int unsigned NW  = $clog2(WaitDepth + 1);
  localparam int unsigned PCW = $clog2(NumCores + 1);
  localparam int unsigned TW  = PW + NW + 1;
  localparam int unsigned FD  = DirLines * (2 ** PW);

  typedef struct packed {
    logic [1:0]          st;
    logic [NumCores-1:0] sh;
    logic [1:0]          sas;   // line state when the head request started
    logic [4:0]          acks;
    logic [NW-1:0]       cnt;
    logic [PW-1:0]       head;
  } rec_t;

  // Restoring fold of a line number into the directory range
  function automatic logic [LW-1:0] fold_line(input logic [7:0] v);
    logic [24:0] r;
    logic [24:0] d;
    r = 25'(v);
    for (int k = 7; k >= 0; k--) begin
      d = 25'(DirLines) << k;
      if (r >= d) r = r - d;
    end
    return LW'(r);
  endfunction

  // Restoring fold of a core id into the core range
  function automatic logic [CW-1:0] fold_core(input logic [3:0] v);
    logic [15:0] r;
    logic [15:0] d;
    r = 16'(v);
    for (int k = 3; k >= 0; k--) begin
      d = 16'(NumCores) << k;
      if (r >= d) r = r - d;
    end
    return CW'(r);
  endfunction

  function automatic logic [PCW-1:0] popcnt(input logic [NumCores-1:0] v);
    logic [PCW-1:0] n;
    n = '0;
    for (int i = 0; i < NumCores; i++) n = n + PCW'(v[i]);
    return n;
  endfunction

  function automatic logic [CW-1:0] lowbit(input logic [NumCores-1:0] v);
    logic [CW-1:0] r;
    r = '0;
    for (int i = NumCores - 1; i >= 0; i--) begin
      if (v[i]) r = CW'(i);
    end
    return r;
  endfunction

  // Storage
  rec_t          rec_mem [DirLines];
  rec_t          rec_rd_q;
  logic [CW:0]   fifo_mem [FD];
  logic [CW:0]   fifo_rd_q;

  rec_t                rec_q, rec_d;
  logic [CW:0]         ent_q, ent_d;
  logic                mwp_q, mwp_d;
  logic [NumCores-1:0] fan_q, fan_d;
  logic [LW-1:0]       clr_cnt_q;
  logic [4:0]          maxs_q, lim_q;

  logic [1:0]    op_q;
  logic [LW-1:0] ln_q;
  logic [CW-1:0] core_q;
  logic          wr_q, rem_q, cwb_q;

  // Emission fields
  logic          emit;
  logic [1:0]    e_kind, e_cst;
  logic [CW-1:0] e_dest;
  logic          e_mrd, e_mwr, e_trap, e_last;

  logic          fifo_we;
  logic [PW-1:0] tail;
  logic [TW-1:0] tail_sum;

  // Head request terms
  logic [NumCores-1:0] r_sh, r_bit, a_bit, f_rest;
  logic [CW-1:0]       r_core, r_low, f_low;
  logic                r_wr, r_hit;
  logic [1:0]          r_st;
  logic [PCW-1:0]      r_cnt, r_cnt2;
  logic [4:0]          maxs_eff;
  logic [PW-1:0]       q_head_nx;
  logic [NW-1:0]       q_cnt_nx;

  assign r_sh     = rec_q.sh;
  assign r_core   = ent_q[CW-1:0];
  assign r_wr     = ent_q[CW];
  assign r_bit    = {{(NumCores-1){1'b0}}, 1'b1} << r_core;
  assign a_bit    = {{(NumCores-1){1'b0}}, 1'b1} << core_q;
  assign r_st     = (r_sh == '0 || rec_q.st > LS_EXC) ? LS_UNC : rec_q.st;
  assign r_cnt    = popcnt(r_sh);
  assign r_low    = lowbit(r_sh);
  assign r_hit    = |(r_sh & r_bit);
  assign r_cnt2   = r_hit ? r_cnt : r_cnt + 1'b1;
  assign maxs_eff = (maxs_q == '0) ? 5'd1 : maxs_q;
  assign q_head_nx = (rec_q.head == PW'(WaitDepth - 1)) ? '0 : rec_q.head + 1'b1;
  assign q_cnt_nx  = rec_q.cnt - 1'b1;
  assign f_low    = lowbit(fan_q);
  assign f_rest   = fan_q & (fan_q - 1'b1);

  // Queue tail slot
  always_comb begin
    tail_sum = TW'(rec_q.head) + TW'(rec_q.cnt);
    if (tail_sum >= TW'(WaitDepth)) tail_sum = tail_sum - TW'(WaitDepth);
    tail = PW'(tail_sum);
  end

  // Step logic
  always_comb begin
    rec_d   = rec_q;
    ent_d   = ent_q;
    mwp_d   = mwp_q;
    fan_d   = fan_q;
    sts_o   = '0;
    fifo_we = 1'b0;
    emit    = 1'b0;
    e_kind  = MSG_NONE;
    e_dest  = '0;
    e_cst   = LS_UNC;
    e_mrd   = 1'b0;
    e_mwr   = mwp_q;
    e_trap  = 1'b0;
    e_last  = 1'b1;

    sts_o.clr_done = (clr_cnt_q == LW'(DirLines - 1));

    if (cmd_i.accept)   mwp_d = 1'b0;
    if (cmd_i.load_rec) rec_d = rec_rd_q;
    if (cmd_i.load_ent) ent_d = fifo_rd_q;

    // Decode the item against its line
    if (cmd_i.dec) begin
      unique case (op_q)
        OP_REQ: begin
          if (rec_q.cnt >= NW'(WaitDepth)) begin
            emit   = 1'b1;
            e_kind = MSG_OVF;
            e_dest = core_q;
          end else begin
            fifo_we   = 1'b1;
            rec_d.cnt = rec_q.cnt + 1'b1;
            if (rec_q.cnt == '0) begin
              ent_d         = {wr_q, core_q};
              sts_o.dec_run = 1'b1;
            end else begin
              emit = 1'b1;
            end
          end
        end
        OP_ACK: begin
          if (rec_q.cnt != '0) sts_o.dec_ack = 1'b1;
          else                 emit          = 1'b1;
        end
        OP_EVICT: begin
          rec_d.sh = rec_q.sh & ~a_bit;
          if ((rec_q.sh & ~a_bit) == '0) rec_d.st = LS_UNC;
          emit  = 1'b1;
          e_mwr = cwb_q;
        end
        default: emit = 1'b1;
      endcase
    end

    // Acknowledgement for the head request
    if (cmd_i.ack) begin
      unique case (rec_q.sas)
        LS_EXC: begin
          if (!rem_q) begin
            mwp_d = 1'b1;
            if (r_wr) begin
              rec_d.sh = rec_q.sh & ~a_bit;
              rec_d.st = LS_UNC;
            end else begin
              rec_d.st = LS_SHR;
            end
          end
          sts_o.ack_run = 1'b1;
        end
        LS_SHR: begin
          if (!rem_q) begin
            rec_d.sh = rec_q.sh & ~a_bit;
            if ((rec_q.sh & ~a_bit) == '0) rec_d.st = LS_UNC;
          end
          if (r_wr) begin
            if (rec_q.acks != '0) rec_d.acks = rec_q.acks - 1'b1;
            sts_o.ack_run = (rec_q.acks <= 5'd1);
          end else begin
            sts_o.ack_run = 1'b1;
          end
        end
        default: ;
      endcase
      if (!sts_o.ack_run) emit = 1'b1;
    end

    // Head request
    if (cmd_i.run) begin
      rec_d.sas  = r_st;
      rec_d.acks = 5'(r_cnt);
      if (r_st == LS_EXC) begin
        emit   = 1'b1;
        e_kind = MSG_INV;
        e_dest = r_low;
        e_cst  = r_wr ? LS_UNC : LS_SHR;
      end else if (r_wr && r_st == LS_SHR) begin
        fan_d         = r_sh;
        sts_o.run_fan = 1'b1;
      end else if (!r_wr && !r_hit && 8'(r_cnt) >= 8'(maxs_eff)) begin
        emit   = 1'b1;
        e_kind = MSG_INV;
        e_dest = r_low;
      end else begin
        // Grant: data reply, then retire the head entry
        emit       = 1'b1;
        e_kind     = MSG_DATA;
        e_dest     = r_core;
        e_mrd      = 1'b1;
        rec_d.head = q_head_nx;
        rec_d.cnt  = q_cnt_nx;
        e_last     = (q_cnt_nx == '0);
        sts_o.run_more = (q_cnt_nx != '0);
        if (r_wr) begin
          rec_d.sh = r_bit;
          rec_d.st = LS_EXC;
          e_cst    = LS_EXC;
        end else begin
          rec_d.sh = r_sh | r_bit;
          rec_d.st = LS_SHR;
          e_cst    = LS_SHR;
          e_trap   = (lim_q != '0) && (8'(r_cnt2) >= 8'(lim_q));
        end
      end
    end

    // Invalidation fan-out, lowest sharer first
    if (cmd_i.fan) begin
      emit           = 1'b1;
      e_kind         = MSG_INV;
      e_dest         = f_low;
      fan_d          = f_rest;
      e_last         = (f_rest == '0);
      sts_o.fan_done = (f_rest == '0);
    end

    if (emit) mwp_d = 1'b0;
  end

  // Line record memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      rec_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.wb) begin
      rec_mem[ln_q] <= rec_q;
    end
    if (cmd_i.accept) rec_rd_q <= rec_mem[fold_line(line_index_i)];
  end

  // Wait queue memory, read at the next head (rec_d.head) every cycle
  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[{ln_q, tail}] <= {wr_q, core_q};
    fifo_rd_q <= fifo_mem[{ln_q, rec_d.head}];
  end

  // Item latch and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      ln_q   <= fold_line(line_index_i);
      core_q <= fold_core(core_id_i);
      wr_q   <= is_write_i;
      rem_q  <= removed_already_i;
      cwb_q  <= carries_writeback_i;
    end
    rec_q <= rec_d;
    ent_q <= ent_d;
    fan_q <= fan_d;
    if (emit) begin
      msg_kind_o        <= e_kind;
      dest_core_o       <= 4'(e_dest);
      new_cache_state_o <= e_cst;
      out_line_o        <= 8'(ln_q);
      memory_read_o     <= e_mrd;
      memory_write_o    <= e_mwr;
      trap_flag_o       <= e_trap;
      last_o            <= e_last;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q      <= '0;
      mwp_q          <= 1'b0;
      result_valid_o <= 1'b0;
      maxs_q         <= MaxSharersRst;
      lim_q          <= LimitlessRst;
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
      mwp_q          <= mwp_d;
      result_valid_o <= emit;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAX_SHARERS: maxs_q <= cfg_data_i;
          CFG_LIMITLESS:   lim_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[sv/cdc_checker.sv]
// Port-level checks for the coherence directory controller, bound to the top.
// Depends on cdc_pkg for the message kind codes.
module cdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [1:0] msg_kind_o,
  input logic       last_o
);
  import cdc_pkg::*;

  // Results only come while an item is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside an item");

  // An accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accept without busy");

  // No result directly follows the final result of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result after last");

  // An overflow is the only result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && msg_kind_o == MSG_OVF) |-> (last_o && !$past(result_valid_o)))
    else $error("overflow not alone");

endmodule

bind coherence_directory_controller cdc_checker u_cdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .msg_kind_o     (msg_kind_o),
  .last_o         (last_o)
);
